### hdl/aosa_pkg.sv
// Shared types and codes for the all-or-nothing slot allocator.
// Used by the front stage, the command queue, the back stage and the top level.
package aosa_pkg;

  localparam int unsigned CountW = 7;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned StatW  = 3;

  localparam logic MODE_GRAB    = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [StatW-1:0] STATUS_GRANTED  = 3'd0;
  localparam logic [StatW-1:0] STATUS_SHORT    = 3'd1;
  localparam logic [StatW-1:0] STATUS_RELEASED = 3'd2;
  localparam logic [StatW-1:0] STATUS_BAD_SLOT = 3'd3;
  localparam logic [StatW-1:0] STATUS_ZERO     = 3'd4;

  typedef enum logic [1:0] {
    CMD_GRAB,
    CMD_ZERO,
    CMD_RELEASE,
    CMD_BAD
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    logic [CountW-1:0] count;
    logic [SlotW-1:0]  slot;
  } cmd_t;

endpackage

### hdl/all_or_nothing_slot_allocator.sv
// A request is registered in the front stage, then waits in the queue.
// A release, bad slot, zero grab or short grab is done from the back stage's idle state, with one result.
// A grab of N slots scans the used map one slot per cycle, waiting at a free slot while the
// output is full; no new command is taken until the scan ends, while the front fills the queue.
// Reset (rst_ni low, asynchronous) frees every slot and empties the queue and output.
// Depends on aosa_pkg, aosa_front, aosa_fifo and aosa_back.
module all_or_nothing_slot_allocator #(
  parameter int unsigned NUM_SLOTS   = 40,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [aosa_pkg::CountW-1:0] count_i,
  input  logic [aosa_pkg::SlotW-1:0]  slot_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [aosa_pkg::SlotW-1:0]  granted_slot_o,
  output logic [aosa_pkg::StatW-1:0]  status_o,
  output logic                        last_o
);
  import aosa_pkg::*;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  aosa_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .count_i    (count_i),
    .slot_i     (slot_i),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready),
    .cmd_o      (front_cmd)
  );

  aosa_fifo #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_data_i (front_cmd),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready),
    .pop_data_o  (back_cmd)
  );

  aosa_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (back_valid),
    .cmd_ready_o   (back_ready),
    .cmd_i         (back_cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .granted_slot_o(granted_slot_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

### hdl/aosa_front.sv
// Front stage: accepts requests, classifies them and holds one command for the queue.
// Depends on aosa_pkg.
module aosa_front #(
  parameter int unsigned NUM_SLOTS = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [aosa_pkg::CountW-1:0]  count_i,
  input  logic [aosa_pkg::SlotW-1:0]   slot_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output aosa_pkg::cmd_t               cmd_o
);
  import aosa_pkg::*;

  logic stage_valid_q, stage_valid_d;
  cmd_t cmd_q, cmd_d;
  cmd_t cmd_class;
  logic in_xfer;

  always_comb begin
    cmd_class.count = count_i;
    cmd_class.slot  = slot_i;
    priority if (mode_i == MODE_RELEASE) begin
      if ({1'b0, slot_i} >= 7'(NUM_SLOTS)) begin
        cmd_class.op = CMD_BAD;
      end else begin
        cmd_class.op = CMD_RELEASE;
      end
    end else if (count_i == '0) begin
      cmd_class.op = CMD_ZERO;
    end else begin
      cmd_class.op = CMD_GRAB;
    end
  end

  assign in_ready_o = !stage_valid_q || cmd_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    cmd_d         = cmd_q;
    if (in_xfer) begin
      stage_valid_d = 1'b1;
      cmd_d         = cmd_class;
    end else if (cmd_ready_i) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = stage_valid_q;
  assign cmd_o       = cmd_q;

endmodule

### hdl/aosa_fifo.sv
// Short command queue between the front and back stages.
// Depends on aosa_pkg for the command type.
module aosa_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  aosa_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output aosa_pkg::cmd_t pop_data_o
);
  import aosa_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/aosa_back.sv
// Back stage: owns the used map and free count, executes commands and drives the
// output register. Depends on aosa_pkg.
module aosa_back #(
  parameter int unsigned NUM_SLOTS = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  aosa_pkg::cmd_t              cmd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [aosa_pkg::SlotW-1:0]  granted_slot_o,
  output logic [aosa_pkg::StatW-1:0]  status_o,
  output logic                        last_o
);
  import aosa_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state_q, state_d;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [CountW-1:0]    free_cnt_q, free_cnt_d;
  logic [CountW-1:0]    rem_q, rem_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [IdxW-1:0]      rel_idx;

  logic             out_valid_q;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [StatW-1:0] status_q, status_d;
  logic             last_q, last_d;
  logic             can_load, out_load;

  assign can_load    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && can_load;
  assign rel_idx     = cmd_i.slot[IdxW-1:0];

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    free_cnt_d = free_cnt_q;
    rem_d      = rem_q;
    idx_d      = idx_q;
    out_load   = 1'b0;
    slot_d     = '0;
    status_d   = STATUS_GRANTED;
    last_d     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && can_load) begin
          out_load = 1'b1;
          unique case (cmd_i.op)
            CMD_GRAB: begin
              if (cmd_i.count > free_cnt_q) begin
                status_d = STATUS_SHORT;
              end else begin
                // The first grant leaves from the scan state.
                out_load   = 1'b0;
                free_cnt_d = free_cnt_q - cmd_i.count;
                rem_d      = cmd_i.count;
                idx_d      = '0;
                state_d    = ST_SCAN;
              end
            end
            CMD_ZERO: begin
              status_d = STATUS_ZERO;
            end
            CMD_RELEASE: begin
              status_d = STATUS_RELEASED;
              if (used_q[rel_idx]) begin
                free_cnt_d = free_cnt_q + CountW'(1);
              end
              used_d[rel_idx] = 1'b0;
            end
            CMD_BAD: begin
              status_d = STATUS_BAD_SLOT;
            end
            default: begin
              status_d = STATUS_BAD_SLOT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Used slots are skipped without waiting on the output register.
        if (used_q[idx_q]) begin
          idx_d = idx_q + IdxW'(1);
        end else if (can_load) begin
          out_load      = 1'b1;
          slot_d        = SlotW'(idx_q);
          status_d      = STATUS_GRANTED;
          last_d        = (rem_q == CountW'(1));
          used_d[idx_q] = 1'b1;
          rem_d         = rem_q - CountW'(1);
          idx_d         = idx_q + IdxW'(1);
          if (rem_q == CountW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      free_cnt_q  <= CountW'(NUM_SLOTS);
      rem_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      free_cnt_q <= free_cnt_d;
      rem_q      <= rem_d;
      idx_q      <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      slot_q   <= slot_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_slot_o = slot_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CountW'(NUM_SLOTS))
    else $error("free count exceeds slot count");

  a_free_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |->
      (int'(free_cnt_q) + $countones(used_q) == int'(NUM_SLOTS)))
    else $error("free count out of step with used map");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (int'(idx_q) < int'(NUM_SLOTS)))
    else $error("scan ran past the last slot");

  a_scan_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rem_q != '0))
    else $error("scan active with nothing left to grant");

endmodule
